// File: hdl/antialiased_line_stepper_assert.svh
// Assertion macros for the line stepper checker.
`ifndef ANTIALIASED_LINE_STEPPER_ASSERT_SVH
`define ANTIALIASED_LINE_STEPPER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define AAL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check a property on every clock edge, reset included.
`define AAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

// File: hdl/aal_pkg.sv
// Types and constants of the anti-aliased line stepper.
package aal_pkg;

	localparam int GRAY_BITS = 8;
	localparam int MODE_BITS = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_IDLE  = 3'd0,
		MODE_VERT  = 3'd1,
		MODE_SH_UP = 3'd2,
		MODE_ST_UP = 3'd3,
		MODE_SH_DN = 3'd4,
		MODE_ST_DN = 3'd5
	} mode_t;

	typedef enum logic {
		BK_RUN,
		BK_DIV
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: hdl/aal_if.sv
// Request and result channel interfaces of the line stepper.
interface aal_item_if #(parameter int COORD_BITS = 12) ();
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic signed [COORD_BITS-1:0] x_start;
	logic signed [COORD_BITS-1:0] y_start;
	logic signed [COORD_BITS-1:0] x_end;
	logic signed [COORD_BITS-1:0] y_end;

	modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
	modport sink (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

interface aal_result_if #(parameter int COORD_BITS = 12) ();
	logic                         valid;
	logic                         ready;
	logic                         pixel_valid;
	logic signed [COORD_BITS-1:0] main_x;
	logic signed [COORD_BITS-1:0] main_y;
	logic [7:0]                   main_gray;
	logic                         side_valid;
	logic signed [COORD_BITS-1:0] side_x;
	logic signed [COORD_BITS-1:0] side_y;
	logic [7:0]                   side_gray;
	logic                         line_done;

	modport source (output valid, pixel_valid, main_x, main_y, main_gray, side_valid,
		side_x, side_y, side_gray, line_done, input ready);
	modport sink (input valid, pixel_valid, main_x, main_y, main_gray, side_valid,
		side_x, side_y, side_gray, line_done, output ready);
endinterface

// File: hdl/aal_fifo.sv
// Two-entry request queue between the classifier and the stepper.
module aal_fifo #(
	parameter int WIDTH = 65
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   pop,
	output logic [WIDTH-1:0]       rdata,
	output aal_pkg::fifo_stat_t    stat
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign rdata      = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/aal_front.sv
// Front end: takes requests, sorts a load into a drawing mode and orders its endpoints.
module aal_front #(
	parameter int COORD_BITS = 12
) (
	aal_item_if.sink                    items,
	input  aal_pkg::fifo_stat_t         stat,
	output logic                        push,
	output logic                        e_op,
	output aal_pkg::mode_t              e_mode,
	output logic                        e_done,
	output logic signed [COORD_BITS-1:0] e_cx,
	output logic signed [COORD_BITS-1:0] e_cy,
	output logic signed [COORD_BITS-1:0] e_mend,
	output logic [COORD_BITS-1:0]       e_num,
	output logic [COORD_BITS-1:0]       e_den
);

	localparam int DW = COORD_BITS + 1;

	logic [DW-1:0]         dx;
	logic [DW-1:0]         dy;
	logic [DW-1:0]         adx_full;
	logic [DW-1:0]         ady_full;
	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic                  dx_neg;
	logic                  dy_neg;
	logic                  dx_zero;
	logic                  dy_zero;
	logic                  dx_pos;
	logic                  dy_pos;
	logic                  shallow;
	logic                  swap;
	logic signed [COORD_BITS-1:0] x0s;
	logic signed [COORD_BITS-1:0] y0s;
	logic signed [COORD_BITS-1:0] x1s;
	logic signed [COORD_BITS-1:0] y1s;

	assign items.ready = !stat.full;
	assign push        = items.valid && !stat.full;
	assign e_op        = items.op;

	always_comb begin
		dx = {items.x_end[COORD_BITS-1], items.x_end}
			- {items.x_start[COORD_BITS-1], items.x_start};
		dy = {items.y_end[COORD_BITS-1], items.y_end}
			- {items.y_start[COORD_BITS-1], items.y_start};
		dx_neg   = dx[DW-1];
		dy_neg   = dy[DW-1];
		dx_zero  = (dx == '0);
		dy_zero  = (dy == '0);
		dx_pos   = !dx_neg && !dx_zero;
		dy_pos   = !dy_neg && !dy_zero;
		adx_full = dx_neg ? (~dx + DW'(1)) : dx;
		ady_full = dy_neg ? (~dy + DW'(1)) : dy;
		adx      = adx_full[COORD_BITS-1:0];
		ady      = ady_full[COORD_BITS-1:0];
		shallow  = (ady <= adx);

		if (dx_zero) begin
			e_mode = aal_pkg::MODE_VERT;
			swap   = dy_neg;
		end else if ((!dy_neg == dx_pos) || dy_zero) begin
			e_mode = shallow ? aal_pkg::MODE_SH_UP : aal_pkg::MODE_ST_UP;
			swap   = shallow ? dx_neg : dy_neg;
		end else begin
			e_mode = shallow ? aal_pkg::MODE_SH_DN : aal_pkg::MODE_ST_DN;
			swap   = shallow ? dx_neg : dy_pos;
		end

		x0s = swap ? items.x_end : items.x_start;
		y0s = swap ? items.y_end : items.y_start;
		x1s = swap ? items.x_start : items.x_end;
		y1s = swap ? items.y_start : items.y_end;

		e_cx   = x0s;
		e_cy   = y0s;
		e_done = dx_zero && dy_zero;
		// shallow lines step along x, all others along y
		if (e_mode == aal_pkg::MODE_SH_UP || e_mode == aal_pkg::MODE_SH_DN) begin
			e_mend = x1s;
			e_num  = ady;
			e_den  = adx;
		end else begin
			e_mend = y1s;
			e_num  = adx;
			e_den  = ady;
		end
	end

endmodule

// File: hdl/aal_back.sv
// Back end: slope divider, per-pixel stepper and result register.
module aal_back #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  aal_pkg::fifo_stat_t          stat,
	output logic                         pop,
	input  logic                         q_op,
	input  aal_pkg::mode_t               q_mode,
	input  logic                         q_done,
	input  logic signed [COORD_BITS-1:0] q_cx,
	input  logic signed [COORD_BITS-1:0] q_cy,
	input  logic signed [COORD_BITS-1:0] q_mend,
	input  logic [COORD_BITS-1:0]        q_num,
	input  logic [COORD_BITS-1:0]        q_den,
	aal_result_if.source                 results
);

	localparam int FW1 = FRAC_BITS + 1;
	localparam int CW  = $clog2(FRAC_BITS + 1);
	localparam int GB  = aal_pkg::GRAY_BITS;
	localparam logic [FRAC_BITS:0]  FX_ONE    = FW1'(1) << FRAC_BITS;
	localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
	localparam logic [CW-1:0]       CNT_FIRST = CW'(FRAC_BITS);

	aal_pkg::back_state_t state_q, state_d;
	aal_pkg::mode_t       mode_q;

	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] mend_q;
	logic [FRAC_BITS-1:0]  acc_q;
	logic [FRAC_BITS:0]    step_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [CW-1:0]         cnt_q;

	logic                  ov_q;
	logic                  pv_q;
	logic [COORD_BITS-1:0] mx_q;
	logic [COORD_BITS-1:0] my_q;
	logic [GB-1:0]         mg_q;
	logic                  sv_q;
	logic [COORD_BITS-1:0] sx_q;
	logic [COORD_BITS-1:0] sy_q;
	logic [GB-1:0]         sg_q;
	logic                  ld_q;

	logic                  can_emit;
	logic                  div_active;
	logic                  pop_step;
	logic                  pop_load;

	// divider
	logic                  div_first;
	logic [COORD_BITS:0]   trial;
	logic                  qbit;
	logic [COORD_BITS:0]   trial_sub;
	logic [COORD_BITS-1:0] rem_next;

	// stepper
	logic [FRAC_BITS+7:0]  acc_x255;
	logic [FRAC_BITS:0]    inv;
	logic [FRAC_BITS+8:0]  inv_x255;
	logic [FRAC_BITS:0]    acc_sum;
	logic                  carry;
	logic [COORD_BITS-1:0] x_inc;
	logic [COORD_BITS-1:0] y_inc;
	logic [COORD_BITS-1:0] y_dec;
	logic [COORD_BITS-1:0] nx;
	logic [COORD_BITS-1:0] ny;
	logic [FRAC_BITS-1:0]  nacc;
	logic [COORD_BITS-1:0] major_new;
	logic                  r_pv;
	logic [COORD_BITS-1:0] r_mx;
	logic [COORD_BITS-1:0] r_my;
	logic [GB-1:0]         r_mg;
	logic                  r_sv;
	logic [COORD_BITS-1:0] r_sx;
	logic [COORD_BITS-1:0] r_sy;
	logic [GB-1:0]         r_sg;
	logic                  r_done;

	assign can_emit = !ov_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aal_pkg::BK_RUN: begin
				if (pop_load && q_mode != aal_pkg::MODE_VERT) begin
					state_d = aal_pkg::BK_DIV;
				end
			end
			aal_pkg::BK_DIV: begin
				if (cnt_q == '0) begin
					state_d = aal_pkg::BK_RUN;
				end
			end
			default: state_d = aal_pkg::BK_RUN;
		endcase
	end

	// state outputs
	always_comb begin
		pop        = 1'b0;
		div_active = 1'b0;
		unique case (state_q)
			aal_pkg::BK_RUN: pop        = !stat.empty && can_emit;
			aal_pkg::BK_DIV: div_active = 1'b1;
			default: begin
				pop        = 1'b0;
				div_active = 1'b0;
			end
		endcase
	end

	assign pop_step = pop && (q_op == aal_pkg::OP_STEP);
	assign pop_load = pop && (q_op == aal_pkg::OP_LOAD);

	// one quotient bit a cycle; the first bit compares without a shift
	always_comb begin
		div_first = (cnt_q == CNT_FIRST);
		trial     = div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
		qbit      = (trial >= {1'b0, den_q});
		trial_sub = trial - {1'b0, den_q};
		rem_next  = qbit ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
	end

	always_comb begin
		acc_x255 = {acc_q, 8'd0} - {8'd0, acc_q};
		inv      = FX_ONE - {1'b0, acc_q};
		inv_x255 = {inv, 8'd0} - {8'd0, inv};
		acc_sum  = {1'b0, acc_q} + step_q;
		carry    = acc_sum[FRAC_BITS];
		x_inc    = cur_x_q + COORD_ONE;
		y_inc    = cur_y_q + COORD_ONE;
		y_dec    = cur_y_q - COORD_ONE;

		nx   = cur_x_q;
		ny   = cur_y_q;
		nacc = acc_q;
		r_pv = 1'b1;
		r_mx = cur_x_q;
		r_my = cur_y_q;
		r_mg = '0;
		r_sv = 1'b0;
		r_sx = '0;
		r_sy = '0;
		r_sg = '0;

		case (mode_q) inside
			aal_pkg::MODE_VERT: begin
				ny = y_inc;
			end
			aal_pkg::MODE_SH_UP, aal_pkg::MODE_ST_UP,
			aal_pkg::MODE_SH_DN, aal_pkg::MODE_ST_DN: begin
				r_sv = 1'b1;
				r_mg = acc_x255[FRAC_BITS+7:FRAC_BITS];
				r_sg = inv_x255[FRAC_BITS+7:FRAC_BITS];
				// drop the whole unit on carry
				nacc = acc_sum[FRAC_BITS-1:0];
				case (mode_q)
					aal_pkg::MODE_SH_UP: begin
						r_sx = cur_x_q;
						r_sy = y_inc;
						ny   = carry ? y_inc : cur_y_q;
						nx   = x_inc;
					end
					aal_pkg::MODE_SH_DN: begin
						r_sx = cur_x_q;
						r_sy = y_dec;
						ny   = carry ? y_dec : cur_y_q;
						nx   = x_inc;
					end
					aal_pkg::MODE_ST_UP: begin
						r_sx = x_inc;
						r_sy = cur_y_q;
						nx   = carry ? x_inc : cur_x_q;
						ny   = y_inc;
					end
					default: begin
						r_sx = x_inc;
						r_sy = cur_y_q;
						nx   = carry ? x_inc : cur_x_q;
						ny   = y_dec;
					end
				endcase
			end
			default: begin
				r_pv = 1'b0;
				r_mx = '0;
				r_my = '0;
			end
		endcase

		major_new = (mode_q == aal_pkg::MODE_SH_UP || mode_q == aal_pkg::MODE_SH_DN)
			? nx : ny;
		r_done = r_pv ? (major_new == mend_q) : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aal_pkg::BK_RUN;
			mode_q  <= aal_pkg::MODE_IDLE;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (pop_load) begin
				mode_q <= q_done ? aal_pkg::MODE_IDLE : q_mode;
				cnt_q  <= CNT_FIRST;
			end else if (pop_step && r_done) begin
				mode_q <= aal_pkg::MODE_IDLE;
			end
			if (div_active) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (pop) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_load) begin
			cur_x_q <= q_cx;
			cur_y_q <= q_cy;
			mend_q  <= q_mend;
			acc_q   <= '0;
			step_q  <= '0;
			rem_q   <= q_num;
			den_q   <= q_den;
			pv_q    <= 1'b0;
			mx_q    <= '0;
			my_q    <= '0;
			mg_q    <= '0;
			sv_q    <= 1'b0;
			sx_q    <= '0;
			sy_q    <= '0;
			sg_q    <= '0;
			ld_q    <= q_done;
		end else if (pop_step) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			acc_q   <= nacc;
			pv_q    <= r_pv;
			mx_q    <= r_mx;
			my_q    <= r_my;
			mg_q    <= r_mg;
			sv_q    <= r_sv;
			sx_q    <= r_sx;
			sy_q    <= r_sy;
			sg_q    <= r_sg;
			ld_q    <= r_done;
		end
		if (div_active) begin
			rem_q <= rem_next;
			if (cnt_q == '0) begin
				step_q <= {quo_q, qbit};
			end else begin
				quo_q <= {quo_q[FRAC_BITS-2:0], qbit};
			end
		end
	end

	assign results.valid       = ov_q;
	assign results.pixel_valid = pv_q;
	assign results.main_x      = mx_q;
	assign results.main_y      = my_q;
	assign results.main_gray   = mg_q;
	assign results.side_valid  = sv_q;
	assign results.side_x      = sx_q;
	assign results.side_y      = sy_q;
	assign results.side_gray   = sg_q;
	assign results.line_done   = ld_q;

endmodule

// File: hdl/antialiased_line_stepper.sv
// Top level of the anti-aliased line stepper.
//
// Requests arrive on items: op = 0 loads a line from its two endpoints,
// op = 1 asks for the next pixel pair. Every request gives exactly one
// result on results, in request order.
// A step result carries the main pixel and, except on vertical lines,
// the side pixel one unit off on the minor axis with the complementary
// gray; line_done marks the last pixel of the line.
// A request passes through the queue and then the result register on its
// way to results. Step requests sustain one per cycle while results is
// ready. A load of a non-vertical line holds the stepper while the slope
// divider produces one quotient bit per cycle; requests keep queuing in
// the two-entry queue. The load result itself leaves as soon as the load
// is taken. When results stalls, the result register holds, the queue
// fills and items.ready drops after two more requests.
// Reset empties the queue, clears results.valid and leaves no line loaded;
// a step with no line gives a result with only line_done set.
module antialiased_line_stepper #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	aal_item_if.sink      items,
	aal_result_if.source  results
);

	localparam int ENTRY_W = 5 * COORD_BITS + 2 + aal_pkg::MODE_BITS;

	aal_pkg::fifo_stat_t          stat;
	logic                         push;
	logic                         pop;
	logic [ENTRY_W-1:0]           wdata;
	logic [ENTRY_W-1:0]           rdata;

	logic                         e_op;
	aal_pkg::mode_t               e_mode;
	logic                         e_done;
	logic signed [COORD_BITS-1:0] e_cx;
	logic signed [COORD_BITS-1:0] e_cy;
	logic signed [COORD_BITS-1:0] e_mend;
	logic [COORD_BITS-1:0]        e_num;
	logic [COORD_BITS-1:0]        e_den;

	logic                         q_op;
	logic [aal_pkg::MODE_BITS-1:0] q_mode_bits;
	logic                         q_done;
	logic signed [COORD_BITS-1:0] q_cx;
	logic signed [COORD_BITS-1:0] q_cy;
	logic signed [COORD_BITS-1:0] q_mend;
	logic [COORD_BITS-1:0]        q_num;
	logic [COORD_BITS-1:0]        q_den;

	aal_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.items (items),
		.stat  (stat),
		.push  (push),
		.e_op  (e_op),
		.e_mode(e_mode),
		.e_done(e_done),
		.e_cx  (e_cx),
		.e_cy  (e_cy),
		.e_mend(e_mend),
		.e_num (e_num),
		.e_den (e_den)
	);

	assign wdata = {e_op, e_mode, e_done, e_cx, e_cy, e_mend, e_num, e_den};

	aal_fifo #(
		.WIDTH(ENTRY_W)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wdata),
		.pop   (pop),
		.rdata (rdata),
		.stat  (stat)
	);

	assign {q_op, q_mode_bits, q_done, q_cx, q_cy, q_mend, q_num, q_den} = rdata;

	aal_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.pop    (pop),
		.q_op   (q_op),
		.q_mode (aal_pkg::mode_t'(q_mode_bits)),
		.q_done (q_done),
		.q_cx   (q_cx),
		.q_cy   (q_cy),
		.q_mend (q_mend),
		.q_num  (q_num),
		.q_den  (q_den),
		.results(results)
	);

endmodule

// File: hdl/aal_checker.sv
// Port-level checker for the line stepper, bound to the top level.
`include "antialiased_line_stepper_assert.svh"

module aal_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic                  pixel_valid,
	input logic [COORD_BITS-1:0] main_x,
	input logic [COORD_BITS-1:0] main_y,
	input logic [7:0]            main_gray,
	input logic                  side_valid,
	input logic [COORD_BITS-1:0] side_x,
	input logic [COORD_BITS-1:0] side_y,
	input logic [7:0]            side_gray,
	input logic                  line_done
);

	logic [4*COORD_BITS+18:0] payload;
	logic [8:0]               gray_sum;
	logic                     stalled;
	logic                     gray_pair_ok;
	logic                     vert_black_ok;

	assign payload = {pixel_valid, main_x, main_y, main_gray, side_valid,
		side_x, side_y, side_gray, line_done};
	assign stalled  = res_valid && !res_ready;
	assign gray_sum = {1'b0, main_gray} + {1'b0, side_gray};
	// two truncated shares of 255 add up to 254 or 255
	assign gray_pair_ok = pixel_valid && (gray_sum == 9'd254 || gray_sum == 9'd255);
	assign vert_black_ok = side_valid || (main_gray == 8'd0 && side_gray == 8'd0);

	`AAL_ASSERT(a_result_hold, clk, arst_n, stalled |=> res_valid && $stable(payload), "result changed while stalled")
	`AAL_ASSERT(a_gray_pair, clk, arst_n, res_valid && side_valid |-> gray_pair_ok, "main and side gray do not complement")
	`AAL_ASSERT(a_vert_black, clk, arst_n, res_valid |-> vert_black_ok, "pixel without side pixel is not black")
	`AAL_ASSERT_ALWAYS(a_reset_quiet, clk, $past(arst_n) == 1'b0 |-> !res_valid, "result valid out of reset")

endmodule

bind antialiased_line_stepper aal_checker #(
	.COORD_BITS(COORD_BITS)
) u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.pixel_valid(results.pixel_valid),
	.main_x     (results.main_x),
	.main_y     (results.main_y),
	.main_gray  (results.main_gray),
	.side_valid (results.side_valid),
	.side_x     (results.side_x),
	.side_y     (results.side_y),
	.side_gray  (results.side_gray),
	.line_done  (results.line_done)
);
